// ===== rtl/core/qalu_pkg.sv =====
// package for the q24.8 fixed-point alu: word geometry, action codes,
// item structs and the stage payload types passed between the pipeline modules
// depends on nothing
`default_nettype none

package qalu_pkg;

  // word geometry
  localparam int WORD_WIDTH    = 32;
  localparam int FRACTION_BITS = 8;
  localparam int OUT_WIDTH     = 32;

  // divider: one quotient bit per stage over the shifted dividend
  localparam int NUM_BITS      = WORD_WIDTH + FRACTION_BITS;
  // front stage, divider stages, output stage
  localparam int PIPE_LATENCY  = NUM_BITS + 2;

  typedef logic signed [WORD_WIDTH-1:0]   word_t;
  typedef logic        [WORD_WIDTH-1:0]   uword_t;
  typedef logic signed [2*WORD_WIDTH-1:0] prod_t;
  typedef logic        [NUM_BITS-1:0]     num_t;

  localparam word_t  WORD_ONE    = word_t'(1);
  localparam word_t  TO_INT_BIAS = word_t'((1 << FRACTION_BITS) - 1);
  localparam uword_t UWORD_ZERO  = '0;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_LT       = 4'd4,
    ACT_GT       = 4'd5,
    ACT_EQ       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_GE       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_e;

  // input item
  typedef struct packed {
    action_e              action;
    logic signed [31:0]   operand_a;
    logic signed [31:0]   operand_b;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] result_value;
    logic                        flag;
  } out_t;

  // front stage output
  typedef struct packed {
    action_e action;
    prod_t   product;
    uword_t  num_mag;
    uword_t  den_mag;
    logic    q_neg;
    logic    div_zero;
    word_t   value;
    logic    flag;
  } front_t;

  // result that rides along the divider stages
  typedef struct packed {
    logic  is_div;
    logic  div_zero;
    logic  q_neg;
    word_t value;
    logic  flag;
  } side_t;

  // one divider stage
  typedef struct packed {
    num_t   num;
    uword_t rem;
    uword_t den;
    side_t  side;
  } div_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/qalu_front.sv =====
// front stage: operand narrowing, all single-step actions, the product
// and the divider operand magnitudes, registered
// depends on qalu_pkg
`default_nettype none

module qalu_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire qalu_pkg::in_t     item_i,
  output logic                   valid_o,
  output qalu_pkg::front_t       fe_o
);

  logic              valid_q;
  qalu_pkg::front_t  fe_d;
  qalu_pkg::front_t  fe_q;
  qalu_pkg::word_t   a;
  qalu_pkg::word_t   b;
  qalu_pkg::uword_t  a_u;
  qalu_pkg::uword_t  b_u;

  // low word bits of each operand, taken as signed
  assign a   = item_i.operand_a[qalu_pkg::WORD_WIDTH-1:0];
  assign b   = item_i.operand_b[qalu_pkg::WORD_WIDTH-1:0];
  assign a_u = item_i.operand_a[qalu_pkg::WORD_WIDTH-1:0];
  assign b_u = item_i.operand_b[qalu_pkg::WORD_WIDTH-1:0];

  // single-step actions, product and divider setup
  always_comb begin
    fe_d          = '0;
    fe_d.action   = item_i.action;
    fe_d.product  = qalu_pkg::prod_t'(a) * qalu_pkg::prod_t'(b);
    fe_d.num_mag  = a[qalu_pkg::WORD_WIDTH-1] ? (qalu_pkg::UWORD_ZERO - a_u) : a_u;
    fe_d.den_mag  = b[qalu_pkg::WORD_WIDTH-1] ? (qalu_pkg::UWORD_ZERO - b_u) : b_u;
    fe_d.q_neg    = a[qalu_pkg::WORD_WIDTH-1] ^ b[qalu_pkg::WORD_WIDTH-1];
    fe_d.div_zero = (b_u == qalu_pkg::UWORD_ZERO);
    fe_d.value    = '0;
    fe_d.flag     = 1'b0;
    case (item_i.action)
      qalu_pkg::ACT_ADD:      fe_d.value = a + b;
      qalu_pkg::ACT_SUB:      fe_d.value = a - b;
      qalu_pkg::ACT_MUL:      fe_d.value = '0;
      qalu_pkg::ACT_DIV:      fe_d.value = '0;
      qalu_pkg::ACT_LT:       fe_d.flag  = (a < b);
      qalu_pkg::ACT_GT:       fe_d.flag  = (a > b);
      qalu_pkg::ACT_EQ:       fe_d.flag  = (a == b);
      qalu_pkg::ACT_LE:       fe_d.flag  = (a <= b);
      qalu_pkg::ACT_GE:       fe_d.flag  = (a >= b);
      qalu_pkg::ACT_NE:       fe_d.flag  = (a != b);
      qalu_pkg::ACT_MIN:      fe_d.value = (a <= b) ? a : b;
      qalu_pkg::ACT_MAX:      fe_d.value = (a >= b) ? a : b;
      qalu_pkg::ACT_INC:      fe_d.value = a + qalu_pkg::WORD_ONE;
      qalu_pkg::ACT_DEC:      fe_d.value = a - qalu_pkg::WORD_ONE;
      qalu_pkg::ACT_FROM_INT: fe_d.value = a <<< qalu_pkg::FRACTION_BITS;
      qalu_pkg::ACT_TO_INT: begin
        // truncate toward zero: bias negative values before the shift
        if (a[qalu_pkg::WORD_WIDTH-1]) begin
          fe_d.value = (a + qalu_pkg::TO_INT_BIAS) >>> qalu_pkg::FRACTION_BITS;
        end else begin
          fe_d.value = a >>> qalu_pkg::FRACTION_BITS;
        end
      end
      default:                fe_d.value = '0;
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    fe_q <= fe_d;
  end

  assign valid_o = valid_q;
  assign fe_o    = fe_q;

endmodule

`default_nettype wire

// ===== rtl/core/qalu_div.sv =====
// pipelined restoring divider, one quotient bit per stage; the results of
// the other actions ride along so every item leaves in order
// depends on qalu_pkg
`default_nettype none

module qalu_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire qalu_pkg::front_t   fe_i,
  output logic                    valid_o,
  output qalu_pkg::div_stage_t    dv_o
);

  logic [qalu_pkg::NUM_BITS-1:0] vld_q;
  qalu_pkg::div_stage_t          entry;
  qalu_pkg::div_stage_t          st_in [qalu_pkg::NUM_BITS];
  qalu_pkg::div_stage_t          st_q  [qalu_pkg::NUM_BITS];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic qalu_pkg::div_stage_t div_step(input qalu_pkg::div_stage_t s);
    logic [qalu_pkg::WORD_WIDTH:0] trial;
    logic [qalu_pkg::WORD_WIDTH:0] diff;
    logic                          ge;
    qalu_pkg::div_stage_t          r;
    trial = {s.rem, s.num[qalu_pkg::NUM_BITS-1]};
    diff  = trial - {1'b0, s.den};
    ge    = (trial >= {1'b0, s.den});
    r     = s;
    r.rem = ge ? diff[qalu_pkg::WORD_WIDTH-1:0] : trial[qalu_pkg::WORD_WIDTH-1:0];
    r.num = {s.num[qalu_pkg::NUM_BITS-2:0], ge};
    return r;
  endfunction

  // entry: shifted dividend magnitude, multiply result picked from the product
  always_comb begin
    entry               = '0;
    entry.num           = {fe_i.num_mag, {qalu_pkg::FRACTION_BITS{1'b0}}};
    entry.rem           = '0;
    entry.den           = fe_i.den_mag;
    entry.side.is_div   = (fe_i.action == qalu_pkg::ACT_DIV);
    entry.side.div_zero = fe_i.div_zero;
    entry.side.q_neg    = fe_i.q_neg;
    entry.side.flag     = fe_i.flag;
    if (fe_i.action == qalu_pkg::ACT_MUL) begin
      entry.side.value = fe_i.product[qalu_pkg::FRACTION_BITS+qalu_pkg::WORD_WIDTH-1:
                                      qalu_pkg::FRACTION_BITS];
    end else begin
      entry.side.value = fe_i.value;
    end
  end

  // stage inputs
  always_comb begin
    st_in[0] = entry;
    for (int k = 1; k < qalu_pkg::NUM_BITS; k++) begin
      st_in[k] = st_q[k-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[qalu_pkg::NUM_BITS-2:0], valid_i};
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < qalu_pkg::NUM_BITS; k++) begin
      st_q[k] <= div_step(st_in[k]);
    end
  end

  assign valid_o = vld_q[qalu_pkg::NUM_BITS-1];
  assign dv_o    = st_q[qalu_pkg::NUM_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/qalu_back.sv =====
// output stage: quotient sign and zero-divisor handling, final select and
// cast to the output width into the result register
// depends on qalu_pkg
`default_nettype none

module qalu_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire qalu_pkg::div_stage_t  dv_i,
  output logic                       strobe_o,
  output qalu_pkg::out_t             result_o
);

  logic             strobe_q;
  qalu_pkg::out_t   result_d;
  qalu_pkg::out_t   result_q;
  qalu_pkg::uword_t quo;
  qalu_pkg::word_t  value;

  assign quo = dv_i.num[qalu_pkg::WORD_WIDTH-1:0];

  // final select
  always_comb begin
    value         = dv_i.side.value;
    result_d.flag = dv_i.side.flag;
    if (dv_i.side.is_div) begin
      if (dv_i.side.div_zero) begin
        value         = '0;
        result_d.flag = 1'b1;
      end else begin
        value         = dv_i.side.q_neg ? (qalu_pkg::UWORD_ZERO - quo) : quo;
        result_d.flag = 1'b0;
      end
    end
    result_d.result_value = qalu_pkg::OUT_WIDTH'(value);
  end

  // strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/q24_8_fixed_point_alu_unit.sv =====
// Signed Q24.8 fixed-point ALU, fully pipelined. An item is taken at every
// clock edge where start is high; busy is always low. Each item gives one
// result on result_o, marked by strobe_o for one cycle, after it passes the
// front stage, the divider stages and the output stage, for every action,
// so results leave in the order items came in, at one item per cycle.
// Pipeline depth is set by the restoring divider: one quotient bit per stage
// over the 40-bit shifted dividend, between one front stage and one output stage.
// The receiver cannot stall; results must be taken when strobed.
// top level: instantiates qalu_front, qalu_div and qalu_back; uses qalu_pkg
`default_nettype none

module q24_8_fixed_point_alu_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire qalu_pkg::in_t   item_i,
  output logic                 strobe_o,
  output qalu_pkg::out_t       result_o
);

  logic                  accept;
  logic                  fe_valid;
  qalu_pkg::front_t      fe;
  logic                  dv_valid;
  qalu_pkg::div_stage_t  dv;

  // no backpressure anywhere in the pipeline
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // front stage
  qalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (fe_valid),
    .fe_o    (fe)
  );

  // divider stages
  qalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .fe_i    (fe),
    .valid_o (dv_valid),
    .dv_o    (dv)
  );

  // output stage
  qalu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .dv_i     (dv),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  // every accepted item comes out as a result strobe at the end of the pipeline
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(qalu_pkg::PIPE_LATENCY) strobe_o)
    else $error("accepted item did not produce a result on time");

  // no result without an item taken at the matching cycle
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, qalu_pkg::PIPE_LATENCY))
    else $error("result strobe without a matching item");

  // zero divisor answers zero with the flag set
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o
     && ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_DIV)
     && ($past(item_i.operand_b[qalu_pkg::WORD_WIDTH-1:0], qalu_pkg::PIPE_LATENCY) == '0))
    |-> (result_o.flag && (result_o.result_value == '0)))
    else $error("divide by zero gave a wrong result");

  // comparisons carry a zero word
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o
     && (($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_LT)
      || ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_GT)
      || ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_EQ)
      || ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_LE)
      || ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_GE)
      || ($past(item_i.action, qalu_pkg::PIPE_LATENCY) == qalu_pkg::ACT_NE)))
    |-> (result_o.result_value == '0))
    else $error("comparison result word not zero");

endmodule

`default_nettype wire
